>>> src/thcc_pkg.sv
`timescale 1ns / 1ps
package thcc_pkg;

  // default fraction bits of angles and curvatures
  localparam int FRAC_BITS_DEF = 20;

  // width of the shared rounding datapath; covers every product for FRAC_BITS of 5 or more
  localparam int RND_W = 80;
  typedef logic signed [RND_W-1:0] wide_t;

  // field widths
  localparam int RADIUS_W = 17;
  localparam int Z_W      = 19;
  localparam int PHI_W    = 23;
  localparam int COT_W    = 21;
  localparam int QPT_W    = 22;

  // bend constants
  localparam int RECIP_330   = 13015052;  // round(2^32 / 330)
  localparam int SCALE_0003  = 1288490;   // round(0.0003 * 2^32)
  localparam int RECIP_6_Q16 = 10923;     // round(2^16 / 6)
  localparam int KX_SHIFT    = 20;
  localparam int BEND_SHIFT  = 18;
  localparam int COT_SHIFT   = 16;
  localparam int RECIP_SHIFT = 16;

  // configuration register indexes
  typedef enum logic {
    CFG_CORR_MODE  = 1'b0,
    CFG_DELTA_MODE = 1'b1
  } cfg_idx_t;

  // correction modes
  localparam logic [1:0] MODE_RAW    = 2'd0;
  localparam logic [1:0] MODE_SECOND = 2'd2;

  // control bits that travel with each item
  typedef struct packed {
    logic valid;
    logic raw;
    logic second;
    logic delta;
  } ctl_t;

  // floor((x + 2^(n-1)) / 2^n), round half up
  function automatic wide_t rnd(input wide_t x, input int unsigned n);
    return ((x >>> (n - 1)) + wide_t'(1)) >>> 1;
  endfunction

endpackage

>>> src/track_hit_coord_correction.sv
`timescale 1ns / 1ps
// channel  | ports                                       | handshake
// ---------+---------------------------------------------+-------------------------------
// hit in   | start, busy, in_*                           | taken when start && !busy
// result   | out_valid, out_eta_coord, out_phi_coord     | one cycle per result, no stall
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data   | written when cfg_valid && cfg_ready
//
// one item per clock; each result passes through every pipeline stage register after its item is taken
// the depth is set by the chain of six dependent multiplies from the bend per length
// to the z cubic term, one multiply per stage, then one stage for the z sum and clamp
// busy and cfg_ready stay 0 and 1: the pipeline always moves
// rst_n (synchronous) clears the valid bits and both mode registers
module track_hit_coord_correction #(
  parameter int FRAC_BITS = thcc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic        [thcc_pkg::RADIUS_W-1:0] in_hit_radius,
  input  logic signed [thcc_pkg::Z_W-1:0]      in_hit_z,
  input  logic signed [thcc_pkg::PHI_W-1:0]    in_hit_global_phi,
  input  logic signed [thcc_pkg::COT_W-1:0]    in_hit_cot_theta,
  input  logic signed [thcc_pkg::Z_W-1:0]      in_raw_eta_coord,
  input  logic signed [thcc_pkg::PHI_W-1:0]    in_raw_phi_coord,
  input  logic        [thcc_pkg::RADIUS_W-1:0] in_target_radius,
  input  logic        [thcc_pkg::RADIUS_W-1:0] in_first_stage_radius,
  input  logic signed [thcc_pkg::QPT_W-1:0]    in_q_over_pt,
  input  logic signed [thcc_pkg::PHI_W-1:0]    in_hough_phi,
  input  logic signed [thcc_pkg::QPT_W-1:0]    in_hough_curv,
  output logic                                out_valid,
  output logic signed [thcc_pkg::Z_W-1:0]      out_eta_coord,
  output logic signed [thcc_pkg::PHI_W-1:0]    out_phi_coord,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic        [1:0]                   cfg_data
);
  import thcc_pkg::*;

  localparam int RW  = RADIUS_W + 1;         // signed radius and radius differences
  localparam int KW  = 26;                   // bend per length
  localparam int UW  = 26;                   // bend angle
  localparam int Z1W = 23;                   // first-order z term
  localparam int WW  = 50 - FRAC_BITS;       // angle squared
  localparam int CW  = 75 - 2 * FRAC_BITS;   // angle cubed
  localparam int C6W = 73 - 2 * FRAC_BITS;   // angle cubed over six
  localparam int AW  = 67 - 2 * FRAC_BITS;   // angle squared times radius
  localparam int BW  = 71 - 2 * FRAC_BITS;   // times cot theta
  localparam int ZCW = 69 - 2 * FRAC_BITS;   // z cubic term
  localparam int PSW = ((C6W > UW) ? C6W : UW) + 4;
  localparam int ZSW = ((ZCW > Z1W) ? ZCW : Z1W) + 3;

  localparam logic signed [PSW-1:0] PHI_HI = PSW'(2 ** (PHI_W - 1) - 1);
  localparam logic signed [PSW-1:0] PHI_LO = PSW'(-(2 ** (PHI_W - 1)));
  localparam logic signed [ZSW-1:0] Z_HI   = ZSW'(2 ** (Z_W - 1) - 1);
  localparam logic signed [ZSW-1:0] Z_LO   = ZSW'(-(2 ** (Z_W - 1)));

  // configuration
  logic [1:0] corr_mode_r;
  logic       delta_mode_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corr_mode_r  <= MODE_RAW;
      delta_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CORR_MODE:  corr_mode_r  <= cfg_data;
        CFG_DELTA_MODE: delta_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control pipeline
  ctl_t s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r, s5_ctl_r, s6_ctl_r, s7_ctl_r;
  ctl_t s1_ctl_nxt;

  always_comb begin
    s1_ctl_nxt.valid  = start && !busy;
    s1_ctl_nxt.raw    = (corr_mode_r == MODE_RAW);
    s1_ctl_nxt.second = (corr_mode_r == MODE_SECOND);
    s1_ctl_nxt.delta  = delta_mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
      s5_ctl_r <= '0;
      s6_ctl_r <= '0;
      s7_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      s4_ctl_r <= s3_ctl_r;
      s5_ctl_r <= s4_ctl_r;
      s6_ctl_r <= s5_ctl_r;
      s7_ctl_r <= s6_ctl_r;
    end
  end

  // stage 1: bend per length, radius offsets
  logic signed [KW-1:0]    s1_kx_r, s1_kx_nxt;
  logic signed [RW-1:0]    s1_d_r, s1_d_nxt;
  logic signed [RW-1:0]    s1_zd_r, s1_zd_nxt;
  logic signed [RW-1:0]    s1_r_r, s1_r_nxt;
  logic signed [RW-1:0]    s1_tr_r, s1_tr_nxt;
  logic signed [Z_W-1:0]   s1_z_r, s1_z_nxt;
  logic signed [PHI_W-1:0] s1_gphi_r, s1_gphi_nxt;
  logic signed [COT_W-1:0] s1_cot_r;
  logic signed [PHI_W-1:0] s1_hphi_r;
  logic                    s1_rpos_r, s1_rpos_nxt;
  logic signed [RW-1:0]    zt_s;

  always_comb begin
    s1_r_nxt  = $signed({1'b0, in_hit_radius});
    s1_tr_nxt = $signed({1'b0, in_target_radius});
    zt_s      = s1_ctl_nxt.delta ? $signed({1'b0, in_first_stage_radius}) : s1_tr_nxt;
    s1_d_nxt  = s1_r_nxt - s1_tr_nxt;
    s1_zd_nxt = s1_r_nxt - zt_s;
    if (s1_ctl_nxt.delta) begin
      s1_kx_nxt = KW'(rnd(wide_t'(in_hough_curv) * wide_t'(SCALE_0003), KX_SHIFT));
    end else begin
      s1_kx_nxt = KW'(rnd(wide_t'(in_q_over_pt) * wide_t'(RECIP_330), KX_SHIFT));
    end
    // raw mode rides through the base sums with every correction term dropped
    s1_gphi_nxt = s1_ctl_nxt.raw ? in_raw_phi_coord : in_hit_global_phi;
    s1_z_nxt    = s1_ctl_nxt.raw ? in_raw_eta_coord : in_hit_z;
    s1_rpos_nxt = (in_hit_radius != '0);
  end

  always_ff @(posedge clk) begin
    s1_kx_r   <= s1_kx_nxt;
    s1_d_r    <= s1_d_nxt;
    s1_zd_r   <= s1_zd_nxt;
    s1_r_r    <= s1_r_nxt;
    s1_tr_r   <= s1_tr_nxt;
    s1_z_r    <= s1_z_nxt;
    s1_gphi_r <= s1_gphi_nxt;
    s1_cot_r  <= in_hit_cot_theta;
    s1_hphi_r <= in_hough_phi;
    s1_rpos_r <= s1_rpos_nxt;
  end

  // stage 2: bend angles and first-order z term
  logic signed [UW-1:0]    s2_a1_r, s2_a1_nxt;
  logic signed [UW-1:0]    s2_ur_r, s2_ur_nxt;
  logic signed [UW-1:0]    s2_ut_r, s2_ut_nxt;
  logic signed [Z1W-1:0]   s2_z1_r, s2_z1_nxt;
  logic signed [RW-1:0]    s2_r_r;
  logic signed [Z_W-1:0]   s2_z_r;
  logic signed [PHI_W-1:0] s2_gphi_r;
  logic signed [COT_W-1:0] s2_cot_r;
  logic signed [PHI_W-1:0] s2_hphi_r;
  logic                    s2_rpos_r;

  always_comb begin
    s2_a1_nxt = UW'(rnd(wide_t'(s1_d_r) * wide_t'(s1_kx_r), BEND_SHIFT));
    s2_ur_nxt = UW'(rnd(wide_t'(s1_r_r) * wide_t'(s1_kx_r), BEND_SHIFT));
    s2_ut_nxt = UW'(rnd(wide_t'(s1_tr_r) * wide_t'(s1_kx_r), BEND_SHIFT));
    s2_z1_nxt = Z1W'(rnd(wide_t'(s1_cot_r) * wide_t'(s1_zd_r), COT_SHIFT));
  end

  always_ff @(posedge clk) begin
    s2_a1_r   <= s2_a1_nxt;
    s2_ur_r   <= s2_ur_nxt;
    s2_ut_r   <= s2_ut_nxt;
    s2_z1_r   <= s2_z1_nxt;
    s2_r_r    <= s1_r_r;
    s2_z_r    <= s1_z_r;
    s2_gphi_r <= s1_gphi_r;
    s2_cot_r  <= s1_cot_r;
    s2_hphi_r <= s1_hphi_r;
    s2_rpos_r <= s1_rpos_r;
  end

  // stage 3: squared angles
  logic signed [WW-1:0]    s3_wr_r, s3_wr_nxt;
  logic signed [WW-1:0]    s3_wt_r, s3_wt_nxt;
  logic signed [UW-1:0]    s3_ur_r, s3_ut_r, s3_a1_r;
  logic signed [Z1W-1:0]   s3_z1_r;
  logic signed [RW-1:0]    s3_r_r;
  logic signed [Z_W-1:0]   s3_z_r;
  logic signed [PHI_W-1:0] s3_gphi_r;
  logic signed [COT_W-1:0] s3_cot_r;
  logic signed [PHI_W-1:0] s3_hphi_r;
  logic                    s3_rpos_r;

  always_comb begin
    s3_wr_nxt = WW'(rnd(wide_t'(s2_ur_r) * wide_t'(s2_ur_r), FRAC_BITS));
    s3_wt_nxt = WW'(rnd(wide_t'(s2_ut_r) * wide_t'(s2_ut_r), FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    s3_wr_r   <= s3_wr_nxt;
    s3_wt_r   <= s3_wt_nxt;
    s3_ur_r   <= s2_ur_r;
    s3_ut_r   <= s2_ut_r;
    s3_a1_r   <= s2_a1_r;
    s3_z1_r   <= s2_z1_r;
    s3_r_r    <= s2_r_r;
    s3_z_r    <= s2_z_r;
    s3_gphi_r <= s2_gphi_r;
    s3_cot_r  <= s2_cot_r;
    s3_hphi_r <= s2_hphi_r;
    s3_rpos_r <= s2_rpos_r;
  end

  // stage 4: cubes, z radius product, first-order sums
  logic signed [CW-1:0]    s4_cr_r, s4_cr_nxt;
  logic signed [CW-1:0]    s4_ct_r, s4_ct_nxt;
  logic signed [AW-1:0]    s4_ar_r, s4_ar_nxt;
  logic signed [PSW-1:0]   s4_bphi_r, s4_bphi_nxt;
  logic signed [ZSW-1:0]   s4_bz_r, s4_bz_nxt;
  logic signed [COT_W-1:0] s4_cot_r;
  logic                    s4_rpos_r;

  always_comb begin
    s4_cr_nxt = CW'(rnd(wide_t'(s3_wr_r) * wide_t'(s3_ur_r), FRAC_BITS));
    s4_ct_nxt = CW'(rnd(wide_t'(s3_wt_r) * wide_t'(s3_ut_r), FRAC_BITS));
    s4_ar_nxt = AW'(rnd(wide_t'(s3_wr_r) * wide_t'(s3_r_r), FRAC_BITS));
    if (s3_ctl_r.raw) begin
      s4_bphi_nxt = PSW'(s3_gphi_r);
      s4_bz_nxt   = ZSW'(s3_z_r);
    end else begin
      // delta mode subtracts the expected phi carried to the target radius
      s4_bphi_nxt = PSW'(s3_gphi_r) + PSW'(s3_a1_r)
                  + (s3_ctl_r.delta ? PSW'(s3_ut_r) - PSW'(s3_hphi_r) : PSW'(0));
      s4_bz_nxt   = ZSW'(s3_z_r) - (s3_rpos_r ? ZSW'(s3_z1_r) : ZSW'(0));
    end
  end

  always_ff @(posedge clk) begin
    s4_cr_r   <= s4_cr_nxt;
    s4_ct_r   <= s4_ct_nxt;
    s4_ar_r   <= s4_ar_nxt;
    s4_bphi_r <= s4_bphi_nxt;
    s4_bz_r   <= s4_bz_nxt;
    s4_cot_r  <= s3_cot_r;
    s4_rpos_r <= s3_rpos_r;
  end

  // stage 5: divide cubes by six, z cubic times cot theta
  logic signed [C6W-1:0] s5_cr6_r, s5_cr6_nxt;
  logic signed [C6W-1:0] s5_ct6_r, s5_ct6_nxt;
  logic signed [BW-1:0]  s5_b_r, s5_b_nxt;
  logic signed [PSW-1:0] s5_bphi_r;
  logic signed [ZSW-1:0] s5_bz_r;
  logic                  s5_rpos_r;

  always_comb begin
    s5_cr6_nxt = C6W'(rnd(wide_t'(s4_cr_r) * wide_t'(RECIP_6_Q16), RECIP_SHIFT));
    s5_ct6_nxt = C6W'(rnd(wide_t'(s4_ct_r) * wide_t'(RECIP_6_Q16), RECIP_SHIFT));
    s5_b_nxt   = BW'(rnd(wide_t'(s4_ar_r) * wide_t'(s4_cot_r), COT_SHIFT));
  end

  always_ff @(posedge clk) begin
    s5_cr6_r  <= s5_cr6_nxt;
    s5_ct6_r  <= s5_ct6_nxt;
    s5_b_r    <= s5_b_nxt;
    s5_bphi_r <= s4_bphi_r;
    s5_bz_r   <= s4_bz_r;
    s5_rpos_r <= s4_rpos_r;
  end

  // stage 6: z cubic over six, phi sum
  logic signed [ZCW-1:0] s6_zc_r, s6_zc_nxt;
  logic signed [PSW-1:0] s6_phi_r, s6_phi_nxt;
  logic signed [ZSW-1:0] s6_bz_r;
  logic                  s6_rpos_r;

  always_comb begin
    s6_zc_nxt  = ZCW'(rnd(wide_t'(s5_b_r) * wide_t'(RECIP_6_Q16), RECIP_SHIFT));
    s6_phi_nxt = s5_bphi_r
               + (s5_ctl_r.second
                  ? PSW'(s5_cr6_r) + (s5_ctl_r.delta ? PSW'(s5_ct6_r) : PSW'(0))
                  : PSW'(0));
  end

  always_ff @(posedge clk) begin
    s6_zc_r   <= s6_zc_nxt;
    s6_phi_r  <= s6_phi_nxt;
    s6_bz_r   <= s5_bz_r;
    s6_rpos_r <= s5_rpos_r;
  end

  // stage 7: z sum and saturation into the output registers
  logic signed [ZSW-1:0]   z_sum;
  logic signed [Z_W-1:0]   s7_eta_r, s7_eta_nxt;
  logic signed [PHI_W-1:0] s7_phi_r, s7_phi_nxt;

  always_comb begin
    z_sum = s6_bz_r - ((s6_ctl_r.second && s6_rpos_r) ? ZSW'(s6_zc_r) : ZSW'(0));
    if (z_sum > Z_HI) begin
      s7_eta_nxt = Z_W'(Z_HI);
    end else if (z_sum < Z_LO) begin
      s7_eta_nxt = Z_W'(Z_LO);
    end else begin
      s7_eta_nxt = Z_W'(z_sum);
    end
    if (s6_phi_r > PHI_HI) begin
      s7_phi_nxt = PHI_W'(PHI_HI);
    end else if (s6_phi_r < PHI_LO) begin
      s7_phi_nxt = PHI_W'(PHI_LO);
    end else begin
      s7_phi_nxt = PHI_W'(s6_phi_r);
    end
  end

  always_ff @(posedge clk) begin
    s7_eta_r <= s7_eta_nxt;
    s7_phi_r <= s7_phi_nxt;
  end

  assign out_valid     = s7_ctl_r.valid;
  assign out_eta_coord = s7_eta_r;
  assign out_phi_coord = s7_phi_r;

`ifndef SYNTHESIS
  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##7 out_valid)
    else $error("accepted item produced no result");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 7))
    else $error("result without an accepted item");

  a_raw_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(corr_mode_r == MODE_RAW, 7)
      |-> out_eta_coord == $past(in_raw_eta_coord, 7)
          && out_phi_coord == $past(in_raw_phi_coord, 7))
    else $error("raw mode result differs from raw coordinates");
`endif

endmodule
